>>> design/sam_pkg.sv
// ----------------------------------------------------------------------------
// Suffix automaton matcher package
// Shared widths, parameter defaults and request mode codes.
// ----------------------------------------------------------------------------
`default_nettype none

package sam_pkg;

    localparam int MAX_LEN_DEF     = 256;
    localparam int SYMBOL_BITS_DEF = 8;

    localparam int MODE_W     = 2;
    localparam int SYM_W      = 8;
    localparam int STATE_CNT_W = 9;
    localparam int DISTINCT_W = 16;
    localparam int LEN_W      = 9;
    localparam int QIDX_W     = 16;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND  = 2'd0,
        MODE_MATCH   = 2'd1,
        MODE_RESTART = 2'd2,
        MODE_CLEAR   = 2'd3
    } t_mode;

endpackage

`default_nettype wire

>>> design/sam_ram.sv
// ----------------------------------------------------------------------------
// Suffix automaton RAM
// Simple dual-port synchronous memory, one write and one registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sam_ram #(
    parameter int DATA_W = 9,
    parameter int ADDR_W = 9
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> design/suffix_automaton_matcher_core.sv
// ----------------------------------------------------------------------------
// Suffix automaton matcher core
// Online suffix automaton build with query matching over a transition RAM.
// ----------------------------------------------------------------------------
// Match: a lookup, then a suffix link walk while it misses; restart and dropped append
// answer from idle. Append: the link walk, then a check when a transition exists; a clone
// adds 2**SYMBOL_BITS row copies plus the redirect walk and 2 node writes.
// Clear and reset: a pass over 2*MAX_LEN*2**SYMBOL_BITS entries, busy high throughout.
// One request at a time; the result strobe lasts one cycle and is never stalled.
`default_nettype none

module suffix_automaton_matcher_core
    import sam_pkg::*;
#(
    parameter int MAX_LEN     = MAX_LEN_DEF,
    parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [MODE_W-1:0]      i_mode,
    input  wire logic [SYM_W-1:0]       i_symbol,
    output logic                        o_valid,
    output logic                        o_overflow,
    output logic [STATE_CNT_W-1:0]      o_state_count,
    output logic [DISTINCT_W-1:0]       o_distinct_count,
    output logic [LEN_W-1:0]            o_match_len,
    output logic [LEN_W-1:0]            o_best_len,
    output logic [QIDX_W-1:0]           o_best_start
);

    localparam int SW = $clog2(2 * MAX_LEN);
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int SB = SYMBOL_BITS;
    localparam int AW = SW + SB;
    localparam int NW = SW + LW;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CLEAR = 9'b000000010,
        S_WALK  = 9'b000000100,
        S_FOUND = 9'b000001000,
        S_COPY  = 9'b000010000,
        S_REDIR = 9'b000100000,
        S_FINX  = 9'b001000000,
        S_FINQ  = 9'b010000000,
        S_MATCH = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic [SB-1:0] r_sym, n_sym;
    logic [SW-1:0] r_x, n_x, r_p, n_p, r_q, n_q, r_y, n_y;
    logic [LW-1:0] r_len_x, n_len_x, r_len_p, n_len_p, r_len_q, n_len_q;
    logic          r_first, n_first, r_walked, n_walked;
    logic [SB-1:0] r_cnt, n_cnt;
    logic [AW-1:0] r_clr, n_clr;
    logic          r_clr_item, n_clr_item;
    logic [SW-1:0] r_last, n_last, r_total, n_total, r_cur_s, n_cur_s;
    logic [LW-1:0] r_text, n_text, r_cur_len, n_cur_len, r_best, n_best;
    logic [DISTINCT_W-1:0] r_distinct, n_distinct;
    logic [QIDX_W-1:0] r_bpos, n_bpos, r_qi, n_qi;
    logic          r_ovf, n_ovf, r_strobe, n_strobe;

    logic          tt_we, nd_we;
    logic [AW-1:0] tt_waddr, tt_raddr;
    logic [SW-1:0] tt_wdata, tt_rdata;
    logic [SW-1:0] nd_waddr, nd_raddr;
    logic [NW-1:0] nd_wdata, nd_rdata;
    logic [SW-1:0] nd_link;
    logic [LW-1:0] nd_len, len_now, len_inc;

    assign nd_link = nd_rdata[NW-1:LW];
    assign nd_len  = nd_rdata[LW-1:0];

    sam_ram #(.DATA_W(SW), .ADDR_W(AW)) u_trans (
        .i_clk  (i_clk),
        .i_we   (tt_we),
        .i_waddr(tt_waddr),
        .i_wdata(tt_wdata),
        .i_raddr(tt_raddr),
        .o_rdata(tt_rdata)
    );

    sam_ram #(.DATA_W(NW), .ADDR_W(SW)) u_node (
        .i_clk  (i_clk),
        .i_we   (nd_we),
        .i_waddr(nd_waddr),
        .i_wdata(nd_wdata),
        .i_raddr(nd_raddr),
        .o_rdata(nd_rdata)
    );

    always_comb begin
        n_state = r_state; n_sym = r_sym; n_x = r_x; n_p = r_p; n_q = r_q; n_y = r_y;
        n_len_x = r_len_x; n_len_p = r_len_p; n_len_q = r_len_q;
        n_first = r_first; n_walked = r_walked; n_cnt = r_cnt; n_clr = r_clr;
        n_clr_item = r_clr_item; n_last = r_last; n_total = r_total; n_cur_s = r_cur_s;
        n_text = r_text; n_cur_len = r_cur_len; n_best = r_best; n_distinct = r_distinct;
        n_bpos = r_bpos; n_qi = r_qi; n_ovf = r_ovf; n_strobe = 1'b0;
        tt_we = 1'b0; tt_waddr = {r_p, r_sym}; tt_wdata = r_x; tt_raddr = {r_p, r_sym};
        nd_we = 1'b0; nd_waddr = r_x; nd_wdata = {r_q, r_len_x}; nd_raddr = r_p;
        len_now = r_cur_len;
        len_inc = r_cur_len + 1'b1;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_sym = i_symbol[SB-1:0];
                    n_ovf = 1'b0;
                    case (t_mode'(i_mode))
                        MODE_APPEND: begin
                            if (r_text >= LW'(MAX_LEN)) begin
                                n_ovf = 1'b1;
                                n_strobe = 1'b1;
                            end else begin
                                n_x = r_total;
                                n_p = r_last;
                                n_total = r_total + 1'b1;
                                n_text = r_text + 1'b1;
                                n_first = 1'b1;
                                tt_raddr = {r_last, i_symbol[SB-1:0]};
                                nd_raddr = r_last;
                                n_state = S_WALK;
                            end
                        end
                        MODE_MATCH: begin
                            tt_raddr = {r_cur_s, i_symbol[SB-1:0]};
                            nd_raddr = r_cur_s;
                            n_walked = 1'b0;
                            n_state = S_MATCH;
                        end
                        MODE_RESTART: begin
                            n_cur_s = '0; n_cur_len = '0; n_best = '0; n_bpos = '0; n_qi = '0;
                            n_strobe = 1'b1;
                        end
                        default: begin
                            n_clr = '0;
                            n_clr_item = 1'b1;
                            n_state = S_CLEAR;
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                n_last = '0; n_total = SW'(1); n_text = '0; n_distinct = '0;
                n_cur_s = '0; n_cur_len = '0; n_best = '0; n_bpos = '0; n_qi = '0;
                tt_we = 1'b1;
                tt_waddr = r_clr;
                tt_wdata = '0;
                if (r_clr == '0) begin
                    nd_we = 1'b1;
                    nd_waddr = '0;
                    nd_wdata = '0;
                end
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                    n_strobe = r_clr_item;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            S_WALK: begin
                len_now = r_first ? nd_len + 1'b1 : r_len_x;
                n_len_x = len_now;
                n_first = 1'b0;
                if (tt_rdata != '0) begin
                    n_q = tt_rdata;
                    n_len_p = nd_len;
                    nd_raddr = tt_rdata;
                    n_state = S_FOUND;
                end else begin
                    tt_we = 1'b1;
                    if (r_p == '0) begin
                        nd_we = 1'b1;
                        nd_wdata = {{SW{1'b0}}, len_now};
                        n_distinct = r_distinct + DISTINCT_W'(len_now);
                        n_last = r_x;
                        n_strobe = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_p = nd_link;
                        tt_raddr = {nd_link, r_sym};
                        nd_raddr = nd_link;
                    end
                end
            end
            S_FOUND: begin
                if (r_len_p + 1'b1 == nd_len) begin
                    nd_we = 1'b1;
                    n_distinct = r_distinct + DISTINCT_W'(r_len_x) - DISTINCT_W'(nd_len);
                    n_last = r_x;
                    n_strobe = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_y = r_total;
                    n_total = r_total + 1'b1;
                    n_len_q = nd_len;
                    nd_we = 1'b1;
                    nd_waddr = r_total;
                    nd_wdata = {nd_link, r_len_p + 1'b1};
                    n_cnt = '0;
                    tt_raddr = {r_q, {SB{1'b0}}};
                    n_state = S_COPY;
                end
            end
            S_COPY: begin
                tt_we = 1'b1;
                tt_waddr = {r_y, r_cnt};
                tt_wdata = tt_rdata;
                if (r_cnt == '1) begin
                    tt_raddr = {r_p, r_sym};
                    nd_raddr = r_p;
                    n_state = S_REDIR;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                    tt_raddr = {r_q, n_cnt};
                end
            end
            S_REDIR: begin
                if (tt_rdata != r_q) begin
                    n_state = S_FINX;
                end else begin
                    tt_we = 1'b1;
                    tt_wdata = r_y;
                    if (r_p == '0) begin
                        n_state = S_FINX;
                    end else begin
                        n_p = nd_link;
                        tt_raddr = {nd_link, r_sym};
                        nd_raddr = nd_link;
                    end
                end
            end
            S_FINX: begin
                nd_we = 1'b1;
                nd_wdata = {r_y, r_len_x};
                n_distinct = r_distinct + DISTINCT_W'(r_len_x)
                           - DISTINCT_W'(LW'(r_len_p + 1'b1));
                n_last = r_x;
                n_state = S_FINQ;
            end
            S_FINQ: begin
                nd_we = 1'b1;
                nd_waddr = r_q;
                nd_wdata = {r_y, r_len_q};
                n_strobe = 1'b1;
                n_state = S_IDLE;
            end
            S_MATCH: begin
                len_now = r_walked ? nd_len : r_cur_len;
                len_inc = len_now + 1'b1;
                n_cur_len = len_now;
                if (tt_rdata != '0) begin
                    n_cur_s = tt_rdata;
                    n_cur_len = len_inc;
                    if (len_inc > r_best) begin
                        n_best = len_inc;
                        n_bpos = r_qi + 1'b1 - QIDX_W'(len_inc);
                    end
                    n_qi = r_qi + 1'b1;
                    n_strobe = 1'b1;
                    n_state = S_IDLE;
                end else if (r_cur_s == '0) begin
                    n_qi = r_qi + 1'b1;
                    n_strobe = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_cur_s = nd_link;
                    n_walked = 1'b1;
                    tt_raddr = {nd_link, r_sym};
                    nd_raddr = nd_link;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR; r_clr <= '0; r_clr_item <= 1'b0; r_strobe <= 1'b0;
            r_ovf <= 1'b0; r_last <= '0; r_total <= SW'(1); r_text <= '0;
            r_distinct <= '0; r_cur_s <= '0; r_cur_len <= '0; r_best <= '0;
            r_bpos <= '0; r_qi <= '0; r_first <= 1'b0; r_walked <= 1'b0; r_cnt <= '0;
        end else begin
            r_state <= n_state; r_clr <= n_clr; r_clr_item <= n_clr_item;
            r_strobe <= n_strobe; r_ovf <= n_ovf; r_last <= n_last; r_total <= n_total;
            r_text <= n_text; r_distinct <= n_distinct; r_cur_s <= n_cur_s;
            r_cur_len <= n_cur_len; r_best <= n_best; r_bpos <= n_bpos; r_qi <= n_qi;
            r_first <= n_first; r_walked <= n_walked; r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym <= n_sym; r_x <= n_x; r_p <= n_p; r_q <= n_q; r_y <= n_y;
        r_len_x <= n_len_x; r_len_p <= n_len_p; r_len_q <= n_len_q;
    end

    assign busy             = (r_state != S_IDLE);
    assign o_valid          = r_strobe;
    assign o_overflow       = r_ovf;
    assign o_state_count    = STATE_CNT_W'(r_total);
    assign o_distinct_count = r_distinct;
    assign o_match_len      = LEN_W'(r_cur_len);
    assign o_best_len       = LEN_W'(r_best);
    assign o_best_start     = r_bpos;

endmodule

`default_nettype wire

>>> sim/tb_suffix_automaton_matcher_core.sv
// ----------------------------------------------------------------------------
// Suffix automaton matcher core testbench
// Drives append, match, restart and clear requests with random gaps, predicts
// each response with a local copy of the automaton and checks every field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_suffix_automaton_matcher_core;
    import sam_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP    = 256;
    localparam int NST    = 2 * CAP;
    localparam int ALPHA  = 256;

    typedef struct packed {
        t_mode            mode;
        logic [SYM_W-1:0] symbol;
    } t_request;

    typedef struct packed {
        logic                   overflow;
        logic [STATE_CNT_W-1:0] state_count;
        logic [DISTINCT_W-1:0]  distinct_count;
        logic [LEN_W-1:0]       match_len;
        logic [LEN_W-1:0]       best_len;
        logic [QIDX_W-1:0]      best_start;
    } t_response;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic [MODE_W-1:0]      i_mode = '0;
    logic [SYM_W-1:0]       i_symbol = '0;
    logic                   busy;
    logic                   o_valid;
    logic                   o_overflow;
    logic [STATE_CNT_W-1:0] o_state_count;
    logic [DISTINCT_W-1:0]  o_distinct_count;
    logic [LEN_W-1:0]       o_match_len;
    logic [LEN_W-1:0]       o_best_len;
    logic [QIDX_W-1:0]      o_best_start;

    t_request  request_queue[$];
    t_response response_queue[$];
    int        fail_count = 0;
    int        idle_gap = 0;

    bit [8:0]  sam_next[0:NST*ALPHA-1];
    bit [8:0]  sam_link[0:NST-1];
    bit [8:0]  sam_len[0:NST-1];
    int        sam_last, sam_states, sam_text, sam_distinct;
    int        cur_state, cur_len, top_len;
    bit [15:0] top_pos, q_pos;

    suffix_automaton_matcher_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_mode          (i_mode),
        .i_symbol        (i_symbol),
        .o_valid         (o_valid),
        .o_overflow      (o_overflow),
        .o_state_count   (o_state_count),
        .o_distinct_count(o_distinct_count),
        .o_match_len     (o_match_len),
        .o_best_len      (o_best_len),
        .o_best_start    (o_best_start)
    );

    always #6 i_clk = ~i_clk;

    function automatic void restart_cursor();
        cur_state = 0;
        cur_len   = 0;
        top_len   = 0;
        top_pos   = '0;
        q_pos     = '0;
    endfunction

    function automatic void clear_automaton();
        foreach (sam_next[k]) sam_next[k] = '0;
        foreach (sam_link[k]) begin
            sam_link[k] = '0;
            sam_len[k]  = '0;
        end
        sam_last     = 0;
        sam_states   = 1;
        sam_text     = 0;
        sam_distinct = 0;
        restart_cursor();
    endfunction

    function automatic void extend_automaton(int c);
        int x, p, q, y;
        bit hit;
        x = sam_states;
        p = sam_last;
        q = 0;
        hit = 0;
        sam_states++;
        sam_text++;
        sam_len[x] = 9'(sam_len[p] + 9'd1);
        forever begin
            if (sam_next[p*ALPHA+c] != 0) begin
                q = sam_next[p*ALPHA+c];
                hit = 1;
                break;
            end
            sam_next[p*ALPHA+c] = 9'(x);
            if (p == 0) break;
            p = sam_link[p];
        end
        if (!hit) begin
            sam_link[x] = '0;
        end else if (sam_len[p] + 1 == sam_len[q]) begin
            sam_link[x] = 9'(q);
        end else begin
            y = sam_states;
            sam_states++;
            for (int a = 0; a < ALPHA; a++) sam_next[y*ALPHA+a] = sam_next[q*ALPHA+a];
            sam_len[y]  = 9'(sam_len[p] + 9'd1);
            sam_link[y] = sam_link[q];
            forever begin
                if (sam_next[p*ALPHA+c] != q) break;
                sam_next[p*ALPHA+c] = 9'(y);
                if (p == 0) break;
                p = sam_link[p];
            end
            sam_link[x] = 9'(y);
            sam_link[q] = 9'(y);
        end
        sam_distinct += int'(sam_len[x]) - int'(sam_len[sam_link[x]]);
        sam_last = x;
    endfunction

    function automatic void follow_query(int c);
        int s;
        s = cur_state;
        while (s != 0 && sam_next[s*ALPHA+c] == 0) begin
            s = sam_link[s];
            cur_len = sam_len[s];
        end
        if (sam_next[s*ALPHA+c] != 0) begin
            s = sam_next[s*ALPHA+c];
            cur_len++;
            if (cur_len > top_len) begin
                top_len = cur_len;
                top_pos = q_pos + 16'd1 - 16'(top_len);
            end
        end
        cur_state = s;
        q_pos++;
    endfunction

    function automatic t_response apply_request(t_request r);
        t_response e;
        e.overflow = 1'b0;
        case (r.mode)
            MODE_APPEND: begin
                if (sam_text >= CAP) e.overflow = 1'b1;
                else extend_automaton(r.symbol);
            end
            MODE_MATCH:   follow_query(r.symbol);
            MODE_RESTART: restart_cursor();
            default:      clear_automaton();
        endcase
        e.state_count    = sam_states[8:0];
        e.distinct_count = sam_distinct[15:0];
        e.match_len      = cur_len[8:0];
        e.best_len       = top_len[8:0];
        e.best_start     = top_pos;
        return e;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                response_queue = {response_queue,
                                  apply_request(t_request'{t_mode'(i_mode), i_symbol})};
            end
            if (!start || !busy) begin
                if (idle_gap > 0) begin
                    idle_gap--;
                    start <= 1'b0;
                end else if (request_queue.size() > 0) begin
                    t_request r;
                    r = request_queue.pop_front();
                    i_mode   <= r.mode;
                    i_symbol <= r.symbol;
                    start    <= 1'b1;
                    idle_gap = pick_gap();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (response_queue.size() == 0) begin
                $error("unexpected response");
                fail_count++;
            end else begin
                t_response e;
                e = response_queue.pop_front();
                if (o_overflow !== e.overflow) begin
                    $error("overflow exp %0d got %0d", e.overflow, o_overflow);
                    fail_count++;
                end
                if (o_state_count !== e.state_count) begin
                    $error("state_count exp %0d got %0d", e.state_count, o_state_count);
                    fail_count++;
                end
                if (o_distinct_count !== e.distinct_count) begin
                    $error("distinct_count exp %0d got %0d", e.distinct_count,
                           o_distinct_count);
                    fail_count++;
                end
                if (o_match_len !== e.match_len) begin
                    $error("match_len exp %0d got %0d", e.match_len, o_match_len);
                    fail_count++;
                end
                if (o_best_len !== e.best_len) begin
                    $error("best_len exp %0d got %0d", e.best_len, o_best_len);
                    fail_count++;
                end
                if (o_best_start !== e.best_start) begin
                    $error("best_start exp %0d got %0d", e.best_start, o_best_start);
                    fail_count++;
                end
            end
        end
    end

    task automatic add_request(t_mode m, int s);
        request_queue = {request_queue, t_request'{m, SYM_W'(s)}};
    endtask

    initial begin
        byte unsigned text[$];
        int           n_app, n_qry, base, spread, pos;
        clear_automaton();

        // directed: extremes, clone-forcing pattern, every mode
        add_request(MODE_APPEND, 8'h00);
        add_request(MODE_APPEND, 8'hFF);
        add_request(MODE_APPEND, 8'h00);
        add_request(MODE_APPEND, 8'h00);
        add_request(MODE_APPEND, 8'hFF);
        add_request(MODE_APPEND, 8'hFF);
        add_request(MODE_MATCH, 8'h55);
        add_request(MODE_MATCH, 8'h00);
        add_request(MODE_MATCH, 8'h00);
        add_request(MODE_MATCH, 8'hFF);
        add_request(MODE_MATCH, 8'hAA);
        add_request(MODE_MATCH, 8'hFF);
        add_request(MODE_APPEND, 8'hAA);
        add_request(MODE_MATCH, 8'hAA);
        add_request(MODE_RESTART, 8'hFF);
        add_request(MODE_MATCH, 8'h00);
        add_request(MODE_MATCH, 8'hFF);
        add_request(MODE_CLEAR, 8'h5A);
        add_request(MODE_MATCH, 8'h00);
        add_request(MODE_APPEND, 8'h80);
        add_request(MODE_APPEND, 8'h80);
        add_request(MODE_MATCH, 8'h80);

        for (int round = 0; round < 12; round++) begin
            base   = $urandom_range(0, 255);
            case ($urandom_range(0, 2))
                0:       spread = 1;
                1:       spread = 3;
                default: spread = 255;
            endcase
            n_app = (round == 5) ? 262 : $urandom_range(15, 50);
            for (int k = 0; k < n_app; k++) begin
                int c;
                c = base ^ $urandom_range(0, spread);
                if (text.size() < CAP) text = {text, 8'(c)};
                add_request(MODE_APPEND, c);
            end
            n_qry = $urandom_range(20, 45);
            for (int k = 0; k < n_qry; k++) begin
                int roll;
                roll = $urandom_range(0, 99);
                if (roll < 4) begin
                    add_request(MODE_RESTART, $urandom_range(0, 255));
                end else if (roll < 22 || text.size() == 0) begin
                    add_request(MODE_MATCH, base ^ $urandom_range(0, 255));
                end else begin
                    pos = $urandom_range(0, text.size() - 1);
                    for (int j = pos; j < text.size() && k < n_qry; j++, k++) begin
                        add_request(MODE_MATCH, text[j]);
                    end
                end
            end
            if (round % 3 == 2) begin
                add_request(MODE_CLEAR, $urandom_range(0, 255));
                text.delete();
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (request_queue.size() == 0 && start == 1'b0 && response_queue.size() == 0);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && response_queue.size() == 0) begin
            $display("PASS suffix_automaton_matcher_core");
        end else begin
            $display("FAIL suffix_automaton_matcher_core");
        end
        $finish;
    end

    initial begin
        #120ms;
        $display("FAIL suffix_automaton_matcher_core");
        $finish;
    end

endmodule

`default_nettype wire
